FILE: hdl/sqp_pkg.sv
// shared constants and beat types of the square portal placer
package sqp_pkg;

  parameter int unsigned GRID_SIZE = 16;
  parameter int unsigned RowW      = $clog2(GRID_SIZE);
  parameter int unsigned CoordW    = 4;

  localparam logic CMD_LEAF  = 1'b0;
  localparam logic CMD_INNER = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CoordW-1:0] corner_x;
    logic [CoordW-1:0] corner_y;
    logic [CoordW-1:0] side;
  } sqp_in_t;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              found;
    logic              range_error;
    logic              last;
  } sqp_out_t;

endpackage

FILE: hdl/sqp_ram.sv
// generic single-port-write ram with registered read
module sqp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/square_portal_placer.sv
// top level: portal placement and perimeter listing over a square bitmap
// One square is taken at a time; the block stalls its input until the square's last result
// has been handed to the output register. The bitmap is kept one grid row per ram word and
// every perimeter point costs one ram read. A leaf square runs the edge scans, up to four
// read-modify-write marks (a read state, then a write state each), then the perimeter walk;
// an inner square runs only the walk, and the walk waits while the output is stalled. An
// out-of-grid square goes straight to its final result beat. Rows carry valid flags cleared
// at reset, so the bitmap is empty right after reset with no clearing pass.
module square_portal_placer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sqp_pkg::sqp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sqp_pkg::sqp_out_t  out_data_o
);
  import sqp_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_MARK_RD, ST_MARK_WR, ST_FINAL} state_e;
  typedef enum logic [1:0] {DIR_COL_INC, DIR_ROW_INC, DIR_COL_DEC, DIR_ROW_DEC} dir_e;
  typedef enum logic [2:0] {
    SEG_TOP, SEG_LEFT, SEG_BOTTOM, SEG_RIGHT,
    SEG_WALK_TOP, SEG_WALK_LEFT, SEG_WALK_BOTTOM, SEG_WALK_RIGHT
  } seg_e;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    dir_e              dir;
    logic [CoordW:0]   cnt;
  } seg_t;

  function automatic seg_t seg_setup(seg_e s, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                     logic [CoordW-1:0] d);
    logic [CoordW-1:0] xd;
    logic [CoordW-1:0] yd;
    logic [CoordW:0]   n0;
    logic [CoordW:0]   n1;
    seg_t              r;
    xd = x + d;
    yd = y + d;
    n0 = {1'b0, d};
    n1 = {1'b0, d} + (CoordW+1)'(1);
    case (s)
      SEG_TOP:         r = '{col: x,  row: y,  dir: DIR_COL_INC, cnt: n1};
      SEG_LEFT:        r = '{col: x,  row: y,  dir: DIR_ROW_INC, cnt: n0};
      SEG_BOTTOM:      r = '{col: x,  row: yd, dir: DIR_COL_INC, cnt: n0};
      SEG_RIGHT:       r = '{col: xd, row: y,  dir: DIR_ROW_INC, cnt: n1};
      SEG_WALK_TOP:    r = '{col: xd, row: y,  dir: DIR_COL_DEC, cnt: n1};
      SEG_WALK_LEFT:   r = '{col: x,  row: y,  dir: DIR_ROW_INC, cnt: n0};
      SEG_WALK_BOTTOM: r = '{col: x,  row: yd, dir: DIR_COL_INC, cnt: n0};
      default:         r = '{col: xd, row: yd, dir: DIR_ROW_DEC, cnt: n0};
    endcase
    return r;
  endfunction

  function automatic seg_e seg_succ(seg_e s);
    seg_e r;
    case (s)
      SEG_TOP:         r = SEG_LEFT;
      SEG_LEFT:        r = SEG_BOTTOM;
      SEG_BOTTOM:      r = SEG_RIGHT;
      SEG_RIGHT:       r = SEG_WALK_TOP;
      SEG_WALK_TOP:    r = SEG_WALK_LEFT;
      SEG_WALK_LEFT:   r = SEG_WALK_BOTTOM;
      default:         r = SEG_WALK_RIGHT;
    endcase
    return r;
  endfunction

  state_e            state_q, state_d;
  seg_e              seg_q, seg_d;
  dir_e              dir_q, dir_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d, d_q, d_d;
  logic              err_q, err_d;
  logic [CoordW-1:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [CoordW:0]   rem_q, rem_d;
  logic              pend_q, pend_d;
  logic [CoordW-1:0] pend_col_q, pend_col_d, pend_row_q, pend_row_d;
  logic              hit_q, hit_d;
  logic              hold_v_q, hold_v_d;
  logic [CoordW-1:0] hold_col_q, hold_col_d, hold_row_q, hold_row_d;
  logic              out_valid_q, out_valid_d;
  sqp_out_t          out_data_q, out_data_d;
  logic [GRID_SIZE-1:0] row_valid_q, row_valid_d;
  logic              rvalid_q, rvalid_d;

  logic                 ram_we, ram_re;
  logic [RowW-1:0]      ram_waddr, ram_raddr;
  logic [GRID_SIZE-1:0] ram_wdata, ram_rdata;

  logic [GRID_SIZE-1:0] row_bits;
  logic                 pend_bit, out_free, is_scan, consume, push, in_err;
  sqp_out_t             push_data;
  logic [CoordW-1:0]    half, mark_col, mark_row;
  seg_e                 seg_first, seg_nxt;
  seg_t                 setup_in, setup_nxt;
  logic [CoordW:0]      sum_x, sum_y;

  sqp_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row_bits = rvalid_q ? ram_rdata : '0;
  assign pend_bit = pend_q & row_bits[pend_col_q[RowW-1:0]];
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_scan  = seg_q inside {SEG_TOP, SEG_LEFT, SEG_BOTTOM, SEG_RIGHT};

  assign sum_x  = {1'b0, in_data_i.corner_x} + {1'b0, in_data_i.side};
  assign sum_y  = {1'b0, in_data_i.corner_y} + {1'b0, in_data_i.side};
  assign in_err = (sum_x > (CoordW+1)'(GRID_SIZE - 1)) || (sum_y > (CoordW+1)'(GRID_SIZE - 1));

  assign seg_first = (in_data_i.cmd == CMD_LEAF) ? SEG_TOP : SEG_WALK_TOP;
  assign seg_nxt   = seg_succ(seg_q);
  assign setup_in  = seg_setup(seg_first, in_data_i.corner_x, in_data_i.corner_y,
                               in_data_i.side);
  assign setup_nxt = seg_setup(seg_nxt, x_q, y_q, d_q);

  // midpoint of the edge being scanned
  assign half = {1'b0, d_q[CoordW-1:1]};
  always_comb begin
    case (seg_q)
      SEG_TOP: begin
        mark_col = x_q + half;
        mark_row = y_q;
      end
      SEG_LEFT: begin
        mark_col = x_q;
        mark_row = y_q + half;
      end
      SEG_BOTTOM: begin
        mark_col = x_q + half;
        mark_row = y_q + d_q;
      end
      default: begin
        mark_col = x_q + d_q;
        mark_row = y_q + half;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    dir_d       = dir_q;
    x_d         = x_q;
    y_d         = y_q;
    d_d         = d_q;
    err_d       = err_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    pend_col_d  = pend_col_q;
    pend_row_d  = pend_row_q;
    hit_d       = hit_q;
    hold_v_d    = hold_v_q;
    hold_col_d  = hold_col_q;
    hold_row_d  = hold_row_q;
    row_valid_d = row_valid_q;
    ram_re      = 1'b0;
    ram_raddr   = cur_row_q[RowW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = mark_row[RowW-1:0];
    ram_wdata   = row_bits | (GRID_SIZE'(1) << mark_col[RowW-1:0]);
    push        = 1'b0;
    push_data   = '0;
    consume     = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d       = in_data_i.corner_x;
          y_d       = in_data_i.corner_y;
          d_d       = in_data_i.side;
          err_d     = in_err;
          seg_d     = seg_first;
          cur_col_d = setup_in.col;
          cur_row_d = setup_in.row;
          dir_d     = setup_in.dir;
          rem_d     = setup_in.cnt;
          hit_d     = 1'b0;
          hold_v_d  = 1'b0;
          pend_d    = 1'b0;
          state_d   = in_err ? ST_FINAL : ST_RUN;
        end
      end
      ST_RUN: begin
        if (pend_q) begin
          if (is_scan) begin
            hit_d = hit_q | pend_bit;
          end else if (pend_bit) begin
            if (hold_v_q && !out_free) begin
              consume = 1'b0;
            end else begin
              if (hold_v_q) begin
                push      = 1'b1;
                push_data = '{point_x: hold_col_q, point_y: hold_row_q, found: 1'b1,
                              range_error: 1'b0, last: 1'b0};
              end
              hold_v_d   = 1'b1;
              hold_col_d = pend_col_q;
              hold_row_d = pend_row_q;
            end
          end
        end
        if (consume) begin
          if (rem_q != '0) begin
            ram_re     = 1'b1;
            pend_d     = 1'b1;
            pend_col_d = cur_col_q;
            pend_row_d = cur_row_q;
            rem_d      = rem_q - (CoordW+1)'(1);
            case (dir_q)
              DIR_COL_INC: cur_col_d = cur_col_q + CoordW'(1);
              DIR_ROW_INC: cur_row_d = cur_row_q + CoordW'(1);
              DIR_COL_DEC: cur_col_d = cur_col_q - CoordW'(1);
              default:     cur_row_d = cur_row_q - CoordW'(1);
            endcase
          end else begin
            pend_d = 1'b0;
            if (is_scan && !(hit_q | pend_bit)) begin
              state_d = ST_MARK_RD;
            end else if (seg_q == SEG_WALK_RIGHT) begin
              state_d = ST_FINAL;
            end else begin
              seg_d     = seg_nxt;
              cur_col_d = setup_nxt.col;
              cur_row_d = setup_nxt.row;
              dir_d     = setup_nxt.dir;
              rem_d     = setup_nxt.cnt;
              hit_d     = 1'b0;
            end
          end
        end
      end
      ST_MARK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = mark_row[RowW-1:0];
        state_d   = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        ram_we                             = 1'b1;
        row_valid_d[mark_row[RowW-1:0]]    = 1'b1;
        seg_d                              = seg_nxt;
        cur_col_d                          = setup_nxt.col;
        cur_row_d                          = setup_nxt.row;
        dir_d                              = setup_nxt.dir;
        rem_d                              = setup_nxt.cnt;
        hit_d                              = 1'b0;
        state_d                            = ST_RUN;
      end
      ST_FINAL: begin
        if (out_free) begin
          push = 1'b1;
          if (hold_v_q) begin
            push_data = '{point_x: hold_col_q, point_y: hold_row_q, found: 1'b1,
                          range_error: 1'b0, last: 1'b1};
          end else begin
            push_data = '{point_x: '0, point_y: '0, found: 1'b0,
                          range_error: err_q, last: 1'b1};
          end
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_free ? push : out_valid_q;
    out_data_d  = push ? push_data : out_data_q;
    rvalid_d    = ram_re ? row_valid_q[ram_raddr] : rvalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= SEG_TOP;
      dir_q       <= DIR_COL_INC;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      hold_v_q    <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      dir_q       <= dir_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      hold_v_q    <= hold_v_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      row_valid_q <= row_valid_d;
      rvalid_q    <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    d_q        <= d_d;
    cur_col_q  <= cur_col_d;
    cur_row_q  <= cur_row_d;
    pend_col_q <= pend_col_d;
    pend_row_q <= pend_row_d;
    hold_col_q <= hold_col_d;
    hold_row_q <= hold_row_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("bitmap read and write in the same cycle");

  a_error_beat_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |-> !out_data_o.found && out_data_o.last)
    else $error("range error beat must be a final beat with no point");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a square was taken");

  a_pend_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RUN |-> !pend_q)
    else $error("pending bitmap read outside of a segment");

endmodule

FILE: test/sqp_checker.sv
// checker for the square portal placer: bitmap predictor and result scoreboard
module sqp_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  sqp_pkg::sqp_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  sqp_pkg::sqp_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import sqp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  bit       portal_map [GRID_SIZE*GRID_SIZE];
  sqp_out_t expected_points [$];
  int       mismatches;

  function automatic bit marked(input int col, input int row);
    return portal_map[(row * GRID_SIZE + col) % (GRID_SIZE * GRID_SIZE)];
  endfunction

  task automatic mark(input int col, input int row);
    portal_map[(row * GRID_SIZE + col) % (GRID_SIZE * GRID_SIZE)] = 1'b1;
  endtask

  task automatic walk_point(input int col, input int row, inout int n);
    sqp_out_t pt;
    if (marked(col, row)) begin
      pt = '0;
      pt.point_x = col[CoordW-1:0];
      pt.point_y = row[CoordW-1:0];
      pt.found = 1'b1;
      expected_points.push_back(pt);
      n++;
    end
  endtask

  task automatic predict_square(input sqp_in_t sq);
    int       x;
    int       y;
    int       d;
    int       n;
    bit       hit;
    sqp_out_t pt;
    x = int'(sq.corner_x);
    y = int'(sq.corner_y);
    d = int'(sq.side);
    n = 0;
    pt = '0;
    if (x + d > GRID_SIZE - 1 || y + d > GRID_SIZE - 1) begin
      pt.range_error = 1'b1;
      pt.last = 1'b1;
      expected_points.push_back(pt);
      return;
    end
    if (sq.cmd == CMD_LEAF) begin
      // top, left, bottom, right; each mark is seen by the later scans
      hit = 1'b0;
      for (int i = 0; i <= d; i++) hit |= marked(x + i, y);
      if (!hit) mark(x + d / 2, y);
      hit = 1'b0;
      for (int i = 0; i < d; i++) hit |= marked(x, y + i);
      if (!hit) mark(x, y + d / 2);
      hit = 1'b0;
      for (int i = 0; i < d; i++) hit |= marked(x + i, y + d);
      if (!hit) mark(x + d / 2, y + d);
      hit = 1'b0;
      for (int i = 0; i <= d; i++) hit |= marked(x + d, y + i);
      if (!hit) mark(x + d, y + d / 2);
    end
    for (int i = 0; i <= d; i++) walk_point(x + d - i, y, n);
    for (int i = 0; i < d; i++) walk_point(x, y + i, n);
    for (int i = 0; i < d; i++) walk_point(x + i, y + d, n);
    for (int i = 0; i < d; i++) walk_point(x + d, y + d - i, n);
    if (n == 0) begin
      pt.last = 1'b1;
      expected_points.push_back(pt);
    end else begin
      pt = expected_points.pop_back();
      pt.last = 1'b1;
      expected_points.push_back(pt);
    end
  endtask

  task automatic check_point(input sqp_out_t got);
    sqp_out_t want;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: x=%0d y=%0d found=%0b err=%0b last=%0b",
                 got.point_x, got.point_y, got.found, got.range_error, got.last);
      return;
    end
    want = expected_points.pop_front();
    if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
        got.found !== want.found || got.range_error !== want.range_error ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp x=%0d y=%0d f=%0b e=%0b l=%0b got x=%0d y=%0d f=%0b e=%0b l=%0b",
                 want.point_x, want.point_y, want.found, want.range_error, want.last,
                 got.point_x, got.point_y, got.found, got.range_error, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (portal_map[i]) portal_map[i] = 1'b0;
      expected_points.delete();
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_point(out_data_i);
      if (in_valid_i && !in_stall_i) predict_square(in_data_i);
      pending_o <= expected_points.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: test/square_portal_placer_tb.sv
// testbench top for the square portal placer: clock, reset, square stimulus and verdict
module square_portal_placer_tb;

  import sqp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int RandomSquares = 280;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  sqp_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  sqp_out_t out_data_o;

  int fail_count;
  int pending_points;
  int cycle_count = 0;
  bit quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  square_portal_placer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  sqp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_points)
  );

  always @(negedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 36);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("square_portal_placer regression: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_square(input logic cmd, input int x, input int y, input int d);
    sqp_in_t sq;
    sq.cmd = cmd;
    sq.corner_x = x[CoordW-1:0];
    sq.corner_y = y[CoordW-1:0];
    sq.side = d[CoordW-1:0];
    while (!quiet && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= sq;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    sqp_in_t parent_sq;
    int      d;
    int      half;
    int      pick;
    parent_sq = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty map, range errors, zero side, corner duplicate, extremes
    send_square(CMD_INNER, 0, 0, 15);
    send_square(CMD_LEAF, 15, 15, 15);
    send_square(CMD_LEAF, 1, 0, 15);
    send_square(CMD_INNER, 0, 1, 15);
    send_square(CMD_LEAF, 15, 0, 1);
    send_square(CMD_LEAF, 0, 0, 0);
    send_square(CMD_LEAF, 4, 4, 0);
    send_square(CMD_INNER, 4, 4, 4);
    send_square(CMD_LEAF, 0, 0, 15);
    send_square(CMD_LEAF, 8, 8, 7);
    send_square(CMD_LEAF, 15, 15, 0);
    send_square(CMD_LEAF, 14, 0, 1);
    send_square(CMD_INNER, 0, 0, 15);
    send_square(CMD_LEAF, 2, 2, 4);
    send_square(CMD_LEAF, 2, 2, 2);
    send_square(CMD_LEAF, 4, 2, 2);
    send_square(CMD_LEAF, 2, 4, 2);
    send_square(CMD_LEAF, 4, 4, 2);
    send_square(CMD_INNER, 2, 2, 4);
    send_square(CMD_LEAF, 10, 1, 3);
    send_square(CMD_LEAF, 0, 10, 5);
    send_square(CMD_INNER, 0, 10, 5);

    for (int n = 0; n < RandomSquares; n++) begin
      quiet = (n >= 100 && n < 160);
      pick = $urandom_range(0, 99);
      if (pick < 70 || parent_sq.side < 2) begin
        // fresh square inside the grid, mostly small
        pick = $urandom_range(0, 99);
        if (pick < 70) d = $urandom_range(0, 4);
        else if (pick < 95) d = $urandom_range(5, 10);
        else d = $urandom_range(11, 15);
        parent_sq.cmd = $urandom_range(0, 99) < 60 ? CMD_LEAF : CMD_INNER;
        parent_sq.corner_x = 4'($urandom_range(0, GRID_SIZE - 1 - d));
        parent_sq.corner_y = 4'($urandom_range(0, GRID_SIZE - 1 - d));
        parent_sq.side = 4'(d);
        send_square(parent_sq.cmd, int'(parent_sq.corner_x), int'(parent_sq.corner_y), d);
      end else if (pick < 85) begin
        // one quadrant of the last fresh or quadrant square, going deeper
        half = int'(parent_sq.side) / 2;
        parent_sq.cmd = $urandom_range(0, 99) < 70 ? CMD_LEAF : CMD_INNER;
        parent_sq.corner_x = 4'(parent_sq.corner_x + $urandom_range(0, 1) * half);
        parent_sq.corner_y = 4'(parent_sq.corner_y + $urandom_range(0, 1) * half);
        parent_sq.side = 4'(half);
        send_square(parent_sq.cmd, int'(parent_sq.corner_x), int'(parent_sq.corner_y), half);
      end else begin
        send_square(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom_range(0, 15));
      end
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    while (pending_points != 0) @(negedge clk_i);
    repeat (160) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("square_portal_placer regression: pass");
    end else begin
      $display("square_portal_placer regression: fail");
    end
    $finish;
  end

endmodule
